>>> sv/mwis_pkg.sv
// ----------------------------------------------------------------------------
// mwis_pkg
// Shared constants, datapath operation codes and status struct for the
// interval-model maximum weight independent set engine.
// ----------------------------------------------------------------------------
package mwis_pkg;

	localparam int MAX_INTERVALS_D = 64;
	localparam int MAX_ENDPOINTS_D = 128;
	localparam int WEIGHT_BITS_D   = 16;

	localparam int POS_BITS  = 7;
	localparam int WIN_BITS  = 16;
	localparam int TOT_BITS  = 22;
	localparam int STAT_BITS = 2;

	localparam logic [TOT_BITS-1:0] TOTAL_MAX = 22'h3FFFFF;

	localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_MANY = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_BAD  = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR,
		OP_RNEXT,
		OP_SCAN_INIT,
		OP_IST_RD,
		OP_SCAN_EV,
		OP_PINIT,
		OP_FINIT,
		OP_BASE_RD,
		OP_BASE_LD,
		OP_CAND_RD,
		OP_CAND_ADD,
		OP_INEXT,
		OP_PWR,
		OP_CB_RD,
		OP_CB_WR,
		OP_TOT_RD,
		OP_TOT_LD,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic last_err;
		logic clr_done;
		logic r_done;
		logic i_last;
		logic found;
		logic fin;
		logic p_more;
		logic match;
		logic cb_match;
	} dp_stat_t;

endpackage

>>> sv/mwis_dp.sv
// ----------------------------------------------------------------------------
// mwis_dp
// Datapath: interval store, suffix and contained score memories, loop
// counters and the compare/add unit, driven one operation per cycle.
// ----------------------------------------------------------------------------
module mwis_dp #(
	parameter int MAX_INTERVALS = mwis_pkg::MAX_INTERVALS_D,
	parameter int MAX_ENDPOINTS = mwis_pkg::MAX_ENDPOINTS_D,
	parameter int WEIGHT_BITS   = mwis_pkg::WEIGHT_BITS_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mwis_pkg::op_t                  op,
	input  logic [mwis_pkg::POS_BITS-1:0]  left_end,
	input  logic [mwis_pkg::POS_BITS-1:0]  right_end,
	input  logic [mwis_pkg::WIN_BITS-1:0]  weight,
	input  logic                           last,
	output mwis_pkg::dp_stat_t             stat,
	output logic [mwis_pkg::TOT_BITS-1:0]  total_weight,
	output logic [mwis_pkg::STAT_BITS-1:0] status
);
	import mwis_pkg::*;

	localparam int EW = $clog2(MAX_ENDPOINTS + 1);
	localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int NW = $clog2(MAX_INTERVALS + 1);
	localparam int SW = WEIGHT_BITS + $clog2(MAX_INTERVALS) + 1;
	localparam int CW = (SW > TOT_BITS) ? SW : TOT_BITS;

	logic [EW-1:0]          lo_mem [MAX_INTERVALS];
	logic [EW-1:0]          hi_mem [MAX_INTERVALS];
	logic [WEIGHT_BITS-1:0] w_mem  [MAX_INTERVALS];
	logic [SW-1:0]          cb_mem [MAX_INTERVALS];
	logic [SW-1:0]          sb_mem [MAX_ENDPOINTS + 1];

	logic [NW-1:0]          cnt_q, i_q;
	logic [EW-1:0]          end_q, r_q, p_q, k_q, minlo_q;
	logic [STAT_BITS-1:0]   err_q, stat_q;
	logic                   found_q, fin_q;
	logic [SW-1:0]          best_q, cbr_q, sbr_q;
	logic [EW-1:0]          lo_q, hi_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [TOT_BITS-1:0]    tot_q;

	logic                 bad, full, store;
	logic [STAT_BITS-1:0] err_nx;
	logic [EW-1:0]        hi1, tgt, sb_addr, sb_wa;
	logic                 sb_rd, sb_we, cb_we;
	logic [IW-1:0]        cb_wa;
	logic [SW-1:0]        sb_wd, cb_wd, cand;
	logic [CW-1:0]        wide;

	assign bad   = (left_end >= right_end) || (int'(right_end) >= MAX_ENDPOINTS);
	assign full  = (cnt_q == NW'(MAX_INTERVALS));
	assign store = !bad && !full;
	assign hi1   = EW'(right_end) + EW'(1);

	always_comb begin
		if (err_q != ST_OK)
			err_nx = err_q;
		else if (bad)
			err_nx = ST_BAD;
		else if (full)
			err_nx = ST_MANY;
		else
			err_nx = ST_OK;
	end

	// final pass walks p = end..1 and works on position p-1
	assign tgt  = fin_q ? p_q - EW'(1) : p_q;
	assign cand = cbr_q + sbr_q;
	assign wide = CW'(sbr_q);

	always_comb begin
		sb_rd = 1'b1;
		case (op)
			OP_BASE_RD: sb_addr = tgt + EW'(1);
			OP_CAND_RD: sb_addr = hi_q + EW'(1);
			OP_CB_RD:   sb_addr = lo_q + EW'(1);
			OP_TOT_RD:  sb_addr = '0;
			default: begin
				sb_addr = '0;
				sb_rd   = 1'b0;
			end
		endcase
	end

	always_comb begin
		sb_we = 1'b0;
		sb_wa = k_q;
		sb_wd = '0;
		cb_we = 1'b0;
		cb_wa = IW'(k_q);
		cb_wd = '0;
		case (op)
			OP_CLR: begin
				sb_we = 1'b1;
				cb_we = (int'(k_q) < MAX_INTERVALS);
			end
			OP_PWR: begin
				sb_we = 1'b1;
				sb_wa = tgt;
				sb_wd = best_q;
			end
			OP_CB_WR: begin
				cb_we = 1'b1;
				cb_wa = i_q[IW-1:0];
				cb_wd = SW'(w_q) + sbr_q;
			end
			default: begin
				sb_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD && store) begin
			lo_mem[cnt_q[IW-1:0]] <= EW'(left_end);
			hi_mem[cnt_q[IW-1:0]] <= EW'(right_end);
			w_mem[cnt_q[IW-1:0]]  <= weight[WEIGHT_BITS-1:0];
		end
		if (op == OP_IST_RD) begin
			lo_q  <= lo_mem[i_q[IW-1:0]];
			hi_q  <= hi_mem[i_q[IW-1:0]];
			w_q   <= w_mem[i_q[IW-1:0]];
			cbr_q <= cb_mem[i_q[IW-1:0]];
		end
		if (cb_we)
			cb_mem[cb_wa] <= cb_wd;
		if (sb_we)
			sb_mem[sb_wa] <= sb_wd;
		if (sb_rd)
			sbr_q <= sb_mem[sb_addr];
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_SCAN_EV: begin
				if (hi_q == r_q && (!found_q || lo_q < minlo_q))
					minlo_q <= lo_q;
			end
			OP_BASE_LD: best_q <= sbr_q;
			OP_CAND_ADD: begin
				if (cand > best_q)
					best_q <= cand;
			end
			default: begin
				best_q <= best_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			end_q   <= '0;
			err_q   <= ST_OK;
			stat_q  <= ST_OK;
			tot_q   <= '0;
			r_q     <= '0;
			p_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
			found_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (store) begin
						cnt_q <= cnt_q + NW'(1);
						if (hi1 > end_q)
							end_q <= hi1;
					end
					err_q <= err_nx;
					r_q   <= '0;
					k_q   <= '0;
					fin_q <= 1'b0;
					if (last) begin
						stat_q <= err_nx;
						tot_q  <= '0;
					end
				end
				OP_CLR:       k_q <= k_q + EW'(1);
				OP_RNEXT:     r_q <= r_q + EW'(1);
				OP_SCAN_INIT: begin
					i_q     <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_EV: begin
					if (hi_q == r_q)
						found_q <= 1'b1;
					i_q <= i_q + NW'(1);
				end
				OP_PINIT: begin
					p_q   <= r_q - EW'(1);
					fin_q <= 1'b0;
				end
				OP_FINIT: begin
					p_q   <= end_q;
					fin_q <= 1'b1;
				end
				OP_BASE_LD:  i_q <= '0;
				OP_CAND_ADD: i_q <= i_q + NW'(1);
				OP_INEXT:    i_q <= i_q + NW'(1);
				OP_CB_WR:    i_q <= i_q + NW'(1);
				OP_PWR:      p_q <= p_q - EW'(1);
				OP_TOT_LD: begin
					if (wide > CW'(TOTAL_MAX))
						tot_q <= TOTAL_MAX;
					else
						tot_q <= wide[TOT_BITS-1:0];
				end
				OP_DONE: begin
					cnt_q <= '0;
					end_q <= '0;
					err_q <= ST_OK;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	assign stat.last_err = (err_nx != ST_OK);
	assign stat.clr_done = (k_q == EW'(MAX_ENDPOINTS));
	assign stat.r_done   = (r_q == end_q);
	assign stat.i_last   = ((i_q + NW'(1)) == cnt_q);
	assign stat.found    = found_q;
	assign stat.fin      = fin_q;
	assign stat.p_more   = fin_q ? (p_q != '0) : (p_q > minlo_q);
	assign stat.match    = (lo_q == tgt) && (fin_q || hi_q < r_q);
	assign stat.cb_match = (hi_q == r_q);

	assign total_weight = tot_q;
	assign status       = stat_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_INTERVALS)
		else $error("interval count beyond store depth");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_DONE |=> cnt_q == '0 && err_q == ST_OK && end_q == '0)
		else $error("set state not cleared after result");

	a_err_total: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_LOAD && last && err_nx != ST_OK |=> tot_q == '0 && stat_q == $past(err_nx))
		else $error("error result not reported with zero total");
endmodule

>>> sv/mwis_ctrl.sv
// ----------------------------------------------------------------------------
// mwis_ctrl
// Sequencer: accepts interval beats; a good set goes through the clear sweep,
// per-endpoint interval DP and final pass; every set ends in a result beat.
// ----------------------------------------------------------------------------
module mwis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	input  mwis_pkg::dp_stat_t stat,
	output mwis_pkg::op_t      op
);
	import mwis_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_CLR   = 18'h00002,
		S_RCHK  = 18'h00004,
		S_SRD   = 18'h00008,
		S_SEV   = 18'h00010,
		S_SDONE = 18'h00020,
		S_PCHK  = 18'h00040,
		S_BASE  = 18'h00080,
		S_IRD   = 18'h00100,
		S_IEV   = 18'h00200,
		S_IADD  = 18'h00400,
		S_PWR   = 18'h00800,
		S_CRD   = 18'h01000,
		S_CEV   = 18'h02000,
		S_CWR   = 18'h04000,
		S_RNX   = 18'h08000,
		S_TOT   = 18'h10000,
		S_OUT   = 18'h20000
	} state_t;

	state_t state_q, state_nx;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_nx = state_q;
		op       = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					if (last)
						state_nx = stat.last_err ? S_OUT : S_CLR;
				end
			end
			S_CLR: begin
				op = OP_CLR;
				if (stat.clr_done)
					state_nx = S_RCHK;
			end
			S_RCHK: begin
				if (stat.r_done) begin
					op       = OP_FINIT;
					state_nx = S_PCHK;
				end else begin
					op       = OP_SCAN_INIT;
					state_nx = S_SRD;
				end
			end
			S_SRD: begin
				op       = OP_IST_RD;
				state_nx = S_SEV;
			end
			S_SEV: begin
				op       = OP_SCAN_EV;
				state_nx = stat.i_last ? S_SDONE : S_SRD;
			end
			S_SDONE: begin
				if (stat.found) begin
					op       = OP_PINIT;
					state_nx = S_PCHK;
				end else begin
					op       = OP_RNEXT;
					state_nx = S_RCHK;
				end
			end
			S_PCHK: begin
				if (stat.p_more) begin
					op       = OP_BASE_RD;
					state_nx = S_BASE;
				end else if (stat.fin) begin
					op       = OP_TOT_RD;
					state_nx = S_TOT;
				end else begin
					op       = OP_SCAN_INIT;
					state_nx = S_CRD;
				end
			end
			S_BASE: begin
				op       = OP_BASE_LD;
				state_nx = S_IRD;
			end
			S_IRD: begin
				op       = OP_IST_RD;
				state_nx = S_IEV;
			end
			S_IEV: begin
				if (stat.match) begin
					op       = OP_CAND_RD;
					state_nx = S_IADD;
				end else begin
					op       = OP_INEXT;
					state_nx = stat.i_last ? S_PWR : S_IRD;
				end
			end
			S_IADD: begin
				op       = OP_CAND_ADD;
				state_nx = stat.i_last ? S_PWR : S_IRD;
			end
			S_PWR: begin
				op       = OP_PWR;
				state_nx = S_PCHK;
			end
			S_CRD: begin
				op       = OP_IST_RD;
				state_nx = S_CEV;
			end
			S_CEV: begin
				if (stat.cb_match) begin
					op       = OP_CB_RD;
					state_nx = S_CWR;
				end else begin
					op       = OP_INEXT;
					state_nx = stat.i_last ? S_RNX : S_CRD;
				end
			end
			S_CWR: begin
				op       = OP_CB_WR;
				state_nx = stat.i_last ? S_RNX : S_CRD;
			end
			S_RNX: begin
				op       = OP_RNEXT;
				state_nx = S_RCHK;
			end
			S_TOT: begin
				op       = OP_TOT_LD;
				state_nx = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					op       = OP_DONE;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end
endmodule

>>> sv/circle_graph_max_weight_independent_set_top.sv
// Flow: interval beats are taken while idle; after the last beat the engine runs a
// clear sweep of MAX_ENDPOINTS+1 entries, then a store scan per endpoint (plus the
// interval DP over suffix positions where an interval ends there), then the final
// pass, the total and the result beat; an errored set goes straight to the result.
// Throughput: one set at a time; input is held off from the last beat until the
// result beat is taken. Reset: asynchronous, active low; idle, empty set, no result.
// ----------------------------------------------------------------------------
// circle_graph_max_weight_independent_set_top
// Maximum weight independent set of weighted intervals via interval DP.
// ----------------------------------------------------------------------------
module circle_graph_max_weight_independent_set_top #(
	parameter int MAX_INTERVALS = mwis_pkg::MAX_INTERVALS_D,
	parameter int MAX_ENDPOINTS = mwis_pkg::MAX_ENDPOINTS_D,
	parameter int WEIGHT_BITS   = mwis_pkg::WEIGHT_BITS_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mwis_pkg::POS_BITS-1:0]  left_end,
	input  logic [mwis_pkg::POS_BITS-1:0]  right_end,
	input  logic [mwis_pkg::WIN_BITS-1:0]  weight,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mwis_pkg::TOT_BITS-1:0]  total_weight,
	output logic [mwis_pkg::STAT_BITS-1:0] status
);
	import mwis_pkg::*;

	op_t      op;
	dp_stat_t stat;

	mwis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.op        (op)
	);

	mwis_dp #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.MAX_ENDPOINTS (MAX_ENDPOINTS),
		.WEIGHT_BITS   (WEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.left_end     (left_end),
		.right_end    (right_end),
		.weight       (weight),
		.last         (last),
		.stat         (stat),
		.total_weight (total_weight),
		.status       (status)
	);
endmodule

>>> tb/sv/tb_circle_graph_max_weight_independent_set_top.sv
// ----------------------------------------------------------------------------
// tb_circle_graph_max_weight_independent_set_top
// Sends interval sets to the weight maximizer and checks each result beat
// against an interval DP predictor: directed corner sets first, then random
// sets with random idles on both sides, a long receiver hold-off and a drain.
// ----------------------------------------------------------------------------
module tb_circle_graph_max_weight_independent_set_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mwis_pkg::*;

	class mwis_scoreboard;
		int unsigned span_lo[MAX_INTERVALS_D];
		int unsigned span_hi[MAX_INTERVALS_D];
		longint unsigned span_w[MAX_INTERVALS_D];
		int unsigned span_cnt;
		int unsigned end_pos;
		logic [STAT_BITS-1:0] first_err;
		logic [TOT_BITS-1:0] exp_total[$];
		logic [STAT_BITS-1:0] exp_status[$];
		int unsigned mismatches;

		function new();
			span_cnt = 0;
			end_pos = 0;
			first_err = ST_OK;
			mismatches = 0;
		endfunction

		function longint unsigned best_weight();
			longint unsigned sfx[MAX_ENDPOINTS_D+1];
			longint unsigned inner[MAX_INTERVALS_D];
			longint unsigned best;
			longint unsigned c;
			int minlo;
			bit found;
			foreach (sfx[k]) sfx[k] = 0;
			foreach (inner[k]) inner[k] = 0;
			for (int r = 0; r < end_pos; r++) begin
				found = 0;
				minlo = 0;
				for (int i = 0; i < span_cnt; i++)
					if (span_hi[i] == r && (!found || span_lo[i] < minlo)) begin
						minlo = span_lo[i];
						found = 1;
					end
				if (!found)
					continue;
				for (int p = r - 1; p > minlo; p--) begin
					best = sfx[p+1];
					for (int i = 0; i < span_cnt; i++)
						if (span_lo[i] == p && span_hi[i] < r) begin
							c = inner[i] + sfx[span_hi[i]+1];
							if (c > best)
								best = c;
						end
					sfx[p] = best;
				end
				for (int i = 0; i < span_cnt; i++)
					if (span_hi[i] == r)
						inner[i] = span_w[i] + sfx[span_lo[i]+1];
			end
			for (int q = end_pos - 1; q >= 0; q--) begin
				best = sfx[q+1];
				for (int i = 0; i < span_cnt; i++)
					if (span_lo[i] == q) begin
						c = inner[i] + sfx[span_hi[i]+1];
						if (c > best)
							best = c;
					end
				sfx[q] = best;
			end
			return sfx[0];
		endfunction

		function void note_beat(int unsigned lo, int unsigned hi, int unsigned w, bit lst);
			longint unsigned tot;
			if (lo >= hi || hi >= MAX_ENDPOINTS_D) begin
				if (first_err == ST_OK)
					first_err = ST_BAD;
			end else if (span_cnt >= MAX_INTERVALS_D) begin
				if (first_err == ST_OK)
					first_err = ST_MANY;
			end else begin
				span_lo[span_cnt] = lo;
				span_hi[span_cnt] = hi;
				// only the low weight bits reach the block
				span_w[span_cnt] = w & ((32'd1 << WEIGHT_BITS_D) - 32'd1);
				span_cnt++;
				if (hi + 1 > end_pos)
					end_pos = hi + 1;
			end
			if (!lst)
				return;
			tot = 0;
			if (first_err == ST_OK) begin
				tot = best_weight();
				if (tot > TOTAL_MAX)
					tot = TOTAL_MAX;
			end
			exp_total.push_back(tot[TOT_BITS-1:0]);
			exp_status.push_back(first_err);
			span_cnt = 0;
			end_pos = 0;
			first_err = ST_OK;
		endfunction

		function void check_result(logic [TOT_BITS-1:0] tot, logic [STAT_BITS-1:0] st);
			logic [TOT_BITS-1:0] et;
			logic [STAT_BITS-1:0] es;
			if (exp_total.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: total=%0d status=%0d", tot, st);
				return;
			end
			et = exp_total.pop_front();
			es = exp_status.pop_front();
			if (tot !== et || st !== es) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: total exp %0d got %0d, status exp %0d got %0d",
						et, tot, es, st);
			end
		endfunction

		function int pending();
			return exp_total.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [POS_BITS-1:0] left_end;
	logic [POS_BITS-1:0] right_end;
	logic [WIN_BITS-1:0] weight;
	logic last;
	logic out_valid;
	logic out_ready;
	logic [TOT_BITS-1:0] total_weight;
	logic [STAT_BITS-1:0] status;

	mwis_scoreboard sb = new();
	bit long_hold = 0;

	circle_graph_max_weight_independent_set_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_end(left_end), .right_end(right_end), .weight(weight), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.total_weight(total_weight), .status(status)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(total_weight, status);

	// receiver: random stall per result beat, one long hold-off on request
	initial begin
		int n;
		out_ready = 0;
		wait (arst_n);
		forever begin
			n = $urandom_range(0, 9);
			if (long_hold) begin
				n = 600;
				long_hold = 0;
			end
			repeat (n) @(posedge clk) out_ready <= 0;
			@(posedge clk) out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_beat(int unsigned lo, int unsigned hi, int unsigned w, bit lst);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		left_end <= POS_BITS'(lo);
		right_end <= POS_BITS'(hi);
		weight <= WIN_BITS'(w);
		last <= lst;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(lo, hi, w, lst);
	endtask

	task automatic drain_results();
		in_valid <= 0;
		while (sb.pending() > 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// random set: mostly short, narrow intervals so the DP stays cheap
	task automatic send_random_set(int cnt);
		int unsigned lo, hi;
		for (int i = 0; i < cnt; i++) begin
			lo = $urandom_range(0, 126);
			hi = lo + $urandom_range(1, 6);
			if (hi > 127)
				hi = 127;
			if ($urandom_range(0, 39) == 0)
				hi = $urandom_range(0, lo);
			send_beat(lo, hi, $urandom, i == cnt - 1);
		end
	endtask

	initial begin
		int beats;
		int cnt;
		bit held_once;
		bit drained_once;
		held_once = 0;
		drained_once = 0;
		arst_n = 0;
		in_valid = 0;
		left_end = 0;
		right_end = 0;
		weight = 0;
		last = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_beat(0, 127, 16'hFFFF, 1);
		send_beat(0, 1, 0, 1);
		send_beat(0, 5, 10, 0);
		send_beat(1, 2, 7, 0);
		send_beat(3, 4, 8, 1);
		send_beat(2, 6, 4, 0);
		send_beat(2, 6, 9, 0);
		send_beat(6, 9, 3, 1);
		send_beat(5, 5, 1, 1);
		send_beat(9, 3, 1, 0);
		send_beat(0, 1, 5, 1);
		send_beat(127, 127, 2, 1);
		// two sets of 65 beats each, both one beat beyond the store depth
		for (int i = 0; i < 64; i++)
			send_beat(i % 16, i % 16 + 1, $urandom, 0);
		send_beat(120, 127, 16'hFFFF, 1);
		for (int i = 0; i < 65; i++)
			send_beat(i % 8, i % 8 + 2, i, i == 64);
		drain_results();

		beats = 0;
		while (beats < 1300) begin
			if (!held_once && beats >= 300) begin
				long_hold = 1;
				held_once = 1;
			end
			if (!drained_once && beats >= 700) begin
				drain_results();
				drained_once = 1;
			end
			cnt = ($urandom_range(0, 59) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
			send_random_set(cnt);
			beats += cnt;
		end
		in_valid <= 0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
